// File: sv/sdsm_pkg.sv
// Shared types and constants for the force/torque dead-stream monitor.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdsm_pkg;

   localparam int NUM_AXES    = 6;   // fx, fy, fz, tx, ty, tz
   localparam int FORCE_AXES  = 3;   // axes 0..2 are force, 3..5 torque
   localparam int AXIS_W      = 32;
   localparam int ABS_W       = 32;  // |a - b| of two 32-bit signed values
   localparam int SUM_W       = 34;  // sum of three ABS_W values
   localparam int THRESH_W    = 40;
   localparam int WEIGHT_W    = 8;
   localparam int LIMIT_W     = 8;
   localparam int PROD_W      = SUM_W + WEIGHT_W;
   localparam int SCORE_W     = 43;
   localparam int COUNT_W     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 40;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(10000);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(10);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(10);
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

   typedef logic [NUM_AXES-1:0][AXIS_W-1:0] sample_type;
   typedef logic [NUM_AXES-1:0][ABS_W-1:0]  absdiff_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WEIGHT    = 2'd1,
      CSR_LIMIT     = 2'd2
   } csr_index_type;

   // Pipeline control handed to each stage
   typedef struct packed {
      logic load;     // stage captures new data this cycle
      logic valid;    // data presented to the stage is a real word
   } stage_ctl_type;

endpackage

`default_nettype wire

// File: sv/sdsm_lane.sv
// One axis lane: holds the previous value of its axis and registers |cur - prev|.
// Depends on sdsm_pkg.
`default_nettype none

module sdsm_lane
   import sdsm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stage_ctl_type     ctl,
   input  wire logic [AXIS_W-1:0] cur,
   output logic      [ABS_W-1:0]  absdiff_ff
);

   logic [AXIS_W-1:0] prev_ff;
   logic [AXIS_W-1:0] prev_in;
   logic [AXIS_W:0]   diff;
   logic [AXIS_W:0]   diff_mag;
   logic [ABS_W-1:0]  absdiff_in;

   // 33-bit signed difference, then magnitude (fits in 32 bits unsigned)
   always_comb begin
      diff       = {cur[AXIS_W-1], cur} - {prev_ff[AXIS_W-1], prev_ff};
      diff_mag   = diff[AXIS_W] ? (~diff + 1'b1) : diff;
      absdiff_in = diff_mag[ABS_W-1:0];
      prev_in    = (ctl.load && ctl.valid) ? cur : prev_ff;
   end

   // previous sample: cleared by reset, replaced on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && ctl.valid) begin
         absdiff_ff <= absdiff_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/sdsm_merge.sv
// Merge stage: sums force lanes, sums torque lanes and applies the torque weight.
// Depends on sdsm_pkg.
`default_nettype none

module sdsm_merge
   import sdsm_pkg::*;
(
   input  wire logic                clock,
   input  wire stage_ctl_type       ctl,
   input  wire absdiff_type         absdiff,
   input  wire logic [WEIGHT_W-1:0] torque_weight,
   input  wire sample_type          sample,
   output logic      [SUM_W-1:0]    fsum_ff,
   output logic      [PROD_W-1:0]   tprod_ff,
   output sample_type               sample_ff
);

   logic [SUM_W-1:0]  fsum_in;
   logic [SUM_W-1:0]  tsum;
   logic [PROD_W-1:0] tprod_in;

   always_comb begin
      fsum_in = SUM_W'(absdiff[0]) + SUM_W'(absdiff[1]) + SUM_W'(absdiff[2]);
      tsum    = SUM_W'(absdiff[FORCE_AXES]) + SUM_W'(absdiff[FORCE_AXES+1])
              + SUM_W'(absdiff[FORCE_AXES+2]);
      // 34 x 8 multiply, registered before the final add
      tprod_in = PROD_W'(tsum) * PROD_W'(torque_weight);
   end

   always_ff @(posedge clock) begin
      if (ctl.load && ctl.valid) begin
         fsum_ff   <= fsum_in;
         tprod_ff  <= tprod_in;
         sample_ff <= sample;
      end
   end

endmodule

`default_nettype wire

// File: sv/sensor_dead_stream_monitor.sv
// Structure: 3 register stages (lanes, merge, score/counter); an accepted word passes
// through the lane, merge and output registers before it can be taken from the result port.
// Throughput: one word per cycle; the pipeline holds only while a result waits on rsp_ready.
// Reset (synchronous): clears pipeline valids, held previous sample, stall counter,
// and restores threshold 10000, torque weight 10, stall limit 10.
// Depends on sdsm_pkg, sdsm_lane, sdsm_merge.
`default_nettype none

module sensor_dead_stream_monitor
   import sdsm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input words
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic signed [31:0]    req_force_x,
   input  wire logic signed [31:0]    req_force_y,
   input  wire logic signed [31:0]    req_force_z,
   input  wire logic signed [31:0]    req_torque_x,
   input  wire logic signed [31:0]    req_torque_y,
   input  wire logic signed [31:0]    req_torque_z,
   // result words
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [31:0]         rsp_out_force_x,
   output logic signed [31:0]         rsp_out_force_y,
   output logic signed [31:0]         rsp_out_force_z,
   output logic signed [31:0]         rsp_out_torque_x,
   output logic signed [31:0]         rsp_out_torque_y,
   output logic signed [31:0]         rsp_out_torque_z,
   output logic [SCORE_W-1:0]         rsp_change_score,
   output logic [COUNT_W-1:0]         rsp_stall_count,
   output logic                       rsp_status,
   // configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                advance;
   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                out_valid_ff, out_valid_in;
   stage_ctl_type       lane_ctl, merge_ctl, out_ctl;
   sample_type          req_sample;
   sample_type          s1_sample_ff;
   sample_type          s2_sample;
   absdiff_type         s1_absdiff;
   logic [SUM_W-1:0]    s2_fsum;
   logic [PROD_W-1:0]   s2_tprod;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [LIMIT_W-1:0]  limit_ff,  limit_in;

   logic [SCORE_W-1:0]  score_in, score_ff;
   logic [COUNT_W-1:0]  count_in, count_ff;
   logic                status_in, status_ff;
   logic                live;
   sample_type          out_sample_ff;

   // whole pipeline moves when the output register is free or being drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   assign req_sample = {req_torque_z, req_torque_y, req_torque_x,
                        req_force_z, req_force_y, req_force_x};

   assign lane_ctl  = '{load: advance, valid: req_valid};
   assign merge_ctl = '{load: advance, valid: s1_valid_ff};
   assign out_ctl   = '{load: advance, valid: s2_valid_ff};

   always_comb begin
      s1_valid_in  = advance ? req_valid    : s1_valid_ff;
      s2_valid_in  = advance ? s1_valid_ff  : s2_valid_ff;
      out_valid_in = advance ? s2_valid_ff  : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // configuration register decode
   always_comb begin
      thresh_in = thresh_ff;
      weight_in = weight_ff;
      limit_in  = limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_WEIGHT:    weight_in = csr_wdata[WEIGHT_W-1:0];
            CSR_LIMIT:     limit_in  = csr_wdata[LIMIT_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         weight_ff <= WEIGHT_RESET;
         limit_ff  <= LIMIT_RESET;
      end else begin
         thresh_ff <= thresh_in;
         weight_ff <= weight_in;
         limit_ff  <= limit_in;
      end
   end

   // stage 1: one difference lane per axis
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      sdsm_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (lane_ctl),
         .cur        (req_sample[g]),
         .absdiff_ff (s1_absdiff[g])
      );
   end

   always_ff @(posedge clock) begin
      if (lane_ctl.load && lane_ctl.valid) begin
         s1_sample_ff <= req_sample;
      end
   end

   // stage 2: merge lanes
   sdsm_merge u_merge (
      .clock         (clock),
      .ctl           (merge_ctl),
      .absdiff       (s1_absdiff),
      .torque_weight (weight_ff),
      .sample        (s1_sample_ff),
      .fsum_ff       (s2_fsum),
      .tprod_ff      (s2_tprod),
      .sample_ff     (s2_sample)
   );

   // stage 3: final score, live test, stall counter update
   always_comb begin
      score_in  = SCORE_W'(s2_fsum) + SCORE_W'(s2_tprod);
      live      = score_in > SCORE_W'(thresh_ff);
      count_in  = count_ff;
      status_in = 1'b0;
      if (live) begin
         count_in = '0;
      end else begin
         count_in  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
         status_in = count_in >= limit_ff;
      end
   end

   // stall counter is state and doubles as the output field
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (out_ctl.load && out_ctl.valid) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ctl.load && out_ctl.valid) begin
         score_ff      <= score_in;
         status_ff     <= status_in;
         out_sample_ff <= s2_sample;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_force_x  = out_sample_ff[0];
   assign rsp_out_force_y  = out_sample_ff[1];
   assign rsp_out_force_z  = out_sample_ff[2];
   assign rsp_out_torque_x = out_sample_ff[3];
   assign rsp_out_torque_y = out_sample_ff[4];
   assign rsp_out_torque_z = out_sample_ff[5];
   assign rsp_change_score = score_ff;
   assign rsp_stall_count  = count_ff;
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire

// File: sv/sdsm_checker.sv
// Port-level checks for sensor_dead_stream_monitor, attached by bind.
// Depends on the top level's port list only.
`default_nettype none

module sdsm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [42:0] rsp_change_score,
   input wire logic [7:0]  rsp_stall_count,
   input wire logic        rsp_status
);

   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_change_score)
         && $stable(rsp_stall_count) && $stable(rsp_status))
      else $error("result word changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // dead status needs at least one low-change word counted
   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_stall_count != 8'd0)
      else $error("dead status with zero stall count");

   // consecutive results: counter clears, steps by one, or stays saturated
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_fire ##1 rsp_fire |-> rsp_stall_count == 8'd0
         || rsp_stall_count == 8'($past(rsp_stall_count) + 8'd1)
         || (rsp_stall_count == 8'd255 && $past(rsp_stall_count) == 8'd255))
      else $error("stall count stepped wrongly");

   // a stalled output blocks new input words
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while output stalled");

endmodule

bind sensor_dead_stream_monitor sdsm_checker u_sdsm_checker (.*);

`default_nettype wire
